FILE: hdl/modexp_pkg.sv
// Package for the modular exponentiation block: item types and field widths.
// No dependencies; used by modular_exponentiation and by the checker and testbench in dv/.
package modexp_pkg;

    localparam int FIELD_W = 63;

    typedef struct packed {
        logic [FIELD_W-1:0] base_value;
        logic [FIELD_W-1:0] exponent;
        logic [FIELD_W-1:0] modulus;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_W-1:0] power_result;
        logic               zero_modulus_error;
    } t_out_item;

endpackage

FILE: hdl/modexp_divrem.sv
// Iterative remainder unit: num mod m, one restoring step per cycle.
// Depends on nothing; instantiated by modular_exponentiation.
module modexp_divrem #(
    parameter int W = 63
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_num,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_rem
);
    localparam int CW = $clog2(W + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_done, n_done;
    logic [W-1:0]  r_num, n_num;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_m, n_m;
    logic [W:0]    w_trial;

    always_comb begin
        n_cnt   = r_cnt;
        n_done  = 1'b0;
        n_num   = r_num;
        n_rem   = r_rem;
        n_m     = r_m;
        w_trial = {r_rem, r_num[W-1]};
        if (i_start) begin
            n_cnt = CW'(W);
            n_num = i_num;
            n_rem = '0;
            n_m   = i_m;
        end else if (r_cnt != '0) begin
            // bring down one bit, subtract the modulus when it fits
            if (w_trial >= {1'b0, r_m}) begin
                w_trial = w_trial - {1'b0, r_m};
            end
            n_rem = w_trial[W-1:0];
            n_num = {r_num[W-2:0], 1'b0};
            n_cnt = r_cnt - 1'b1;
            n_done = (r_cnt == CW'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_done <= n_done;
        end
        r_num <= n_num;
        r_rem <= n_rem;
        r_m   <= n_m;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;
endmodule

FILE: hdl/modexp_mulmod.sv
// Shared multiply-and-reduce unit: (a * b) mod m by shift-and-add, one
// multiplier bit per cycle. Requires a < m. Instantiated by modular_exponentiation.
module modexp_mulmod #(
    parameter int W = 63
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    input  logic [W-1:0] i_m,
    output logic         o_done,
    output logic [W-1:0] o_acc
);
    logic         r_busy, n_busy;
    logic         r_done, n_done;
    logic [W-1:0] r_acc, n_acc;
    logic [W-1:0] r_a, n_a;
    logic [W-1:0] r_b, n_b;
    logic [W-1:0] r_m, n_m;
    logic [W:0]   w_sum_acc, w_sum_dbl;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_acc  = r_acc;
        n_a    = r_a;
        n_b    = r_b;
        n_m    = r_m;
        w_sum_acc = {1'b0, r_acc} + {1'b0, r_a};
        w_sum_dbl = {1'b0, r_a} + {1'b0, r_a};
        if (w_sum_acc >= {1'b0, r_m}) begin
            w_sum_acc = w_sum_acc - {1'b0, r_m};
        end
        if (w_sum_dbl >= {1'b0, r_m}) begin
            w_sum_dbl = w_sum_dbl - {1'b0, r_m};
        end
        if (i_start) begin
            n_busy = 1'b1;
            n_acc  = '0;
            n_a    = i_a;
            n_b    = i_b;
            n_m    = i_m;
        end else if (r_busy) begin
            if (r_b == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                if (r_b[0]) begin
                    n_acc = w_sum_acc[W-1:0];
                end
                n_a = w_sum_dbl[W-1:0];
                n_b = {1'b0, r_b[W-1:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_acc <= n_acc;
        r_a   <= n_a;
        r_b   <= n_b;
        r_m   <= n_m;
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule

FILE: hdl/modular_exponentiation.sv
// Top level of the modular exponentiation block: sequencer and output register.
// Depends on modexp_pkg, modexp_divrem and modexp_mulmod.
//
// Computes base_value ** exponent mod modulus by right-to-left square-and-multiply,
// using the low OPERAND_WIDTH bits of each field. One item is worked on at a
// time; o_in_stall is high from acceptance until the result is loaded into the
// output register, which then waits for the consumer while the next item is
// taken. An item first has its base reduced in the remainder unit. Then each
// exponent bit below the top one costs one square and each set bit one
// multiply, all in the single shared multiply-and-reduce unit. A zero
// exponent answers 1 unreduced; a zero modulus answers 0 with
// zero_modulus_error set.
module modular_exponentiation #(
    parameter int OPERAND_WIDTH = 63
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  modexp_pkg::t_in_item  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output modexp_pkg::t_out_item o_out
);
    import modexp_pkg::*;

    localparam int W = OPERAND_WIDTH;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RED  = 6'b000010,
        S_STEP = 6'b000100,
        S_MUL  = 6'b001000,
        S_SQR  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state       r_state, n_state;
    logic [W-1:0] r_b, n_b;
    logic [W-1:0] r_e, n_e;
    logic [W-1:0] r_m, n_m;
    logic [W-1:0] r_r, n_r;
    logic         r_err, n_err;
    logic         r_out_valid, n_out_valid;
    t_out_item    r_out, n_out;

    // remainder unit starts the cycle after acceptance, from registered operands
    logic         r_red_kick;

    logic         w_red_done;
    logic [W-1:0] w_red_rem;
    logic         w_mul_start, w_mul_done;
    logic [W-1:0] w_mul_a, w_mul_b, w_mul_acc;
    logic         w_accept;

    assign w_accept = i_in_valid && (r_state == S_IDLE);

    modexp_divrem #(.W(W)) u_divrem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_red_kick),
        .i_num   (r_b),
        .i_m     (r_m),
        .o_done  (w_red_done),
        .o_rem   (w_red_rem)
    );

    modexp_mulmod #(.W(W)) u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .i_m     (r_m),
        .o_done  (w_mul_done),
        .o_acc   (w_mul_acc)
    );

    always_comb begin
        n_state     = r_state;
        n_b         = r_b;
        n_e         = r_e;
        n_m         = r_m;
        n_r         = r_r;
        n_err       = r_err;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        w_mul_start = 1'b0;
        // multiply: r mod m times b; any r mod 1 is zero, else r < m already
        w_mul_a     = (r_m == W'(1)) ? '0 : r_r;
        w_mul_b     = r_b;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_b   = i_in.base_value[W-1:0];
                    n_e   = i_in.exponent[W-1:0];
                    n_m   = i_in.modulus[W-1:0];
                    n_r   = W'(1);
                    n_err = (i_in.modulus[W-1:0] == '0);
                    n_state = n_err ? S_DONE : S_RED;
                end
            end
            S_RED: begin
                // kick the remainder unit on entry, then wait for it
                if (w_red_done) begin
                    n_b     = w_red_rem;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (r_e == '0) begin
                    n_state = S_DONE;
                end else if (r_e[0]) begin
                    // multiply first, clear the bit, square on return while bits remain
                    w_mul_start = 1'b1;
                    n_e         = {r_e[W-1:1], 1'b0};
                    n_state     = S_MUL;
                end else begin
                    w_mul_start = 1'b1;
                    w_mul_a     = r_b;
                    n_e         = {1'b0, r_e[W-1:1]};
                    n_state     = (r_e[W-1:1] == '0) ? S_DONE : S_SQR;
                    // drop the square when no exponent bits remain
                    if (r_e[W-1:1] == '0) begin
                        w_mul_start = 1'b0;
                    end
                end
            end
            S_MUL: begin
                if (w_mul_done) begin
                    n_r     = w_mul_acc;
                    n_state = S_STEP;
                end
            end
            S_SQR: begin
                if (w_mul_done) begin
                    n_b     = w_mul_acc;
                    n_state = S_STEP;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out.power_result       = r_err ? '0 : FIELD_W'(r_r);
                    n_out.zero_modulus_error = r_err;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_red_kick  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_red_kick  <= w_accept && (i_in.modulus[W-1:0] != '0);
        end
        r_b   <= n_b;
        r_e   <= n_e;
        r_m   <= n_m;
        r_r   <= n_r;
        r_err <= n_err;
        r_out <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

FILE: dv/modexp_checker.sv
// Checker for the modular exponentiation block: watches both channels, predicts
// each result from the accepted item and compares. Depends on modexp_pkg.
`timescale 1ns / 100ps

module modexp_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  modexp_pkg::t_in_item  i_in,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  modexp_pkg::t_out_item i_out,
    output int                    o_fail_count,
    output int                    o_pending,
    output int                    o_seen
);
    import modexp_pkg::*;

    t_out_item expected_results[$];

    // (a * b) mod m by shift-and-add at 64 bits; a, b < m < 2^63
    function automatic logic [63:0] mul_reduce(logic [63:0] a, logic [63:0] b,
                                               logic [63:0] m);
        logic [63:0] acc;
        acc = 0;
        while (b != 0) begin
            if (b[0]) begin
                acc = acc + a;
                if (acc >= m) acc = acc - m;
            end
            a = a + a;
            if (a >= m) a = a - m;
            b = b >> 1;
        end
        return acc;
    endfunction

    function automatic t_out_item power_mod(t_in_item it);
        t_out_item   r;
        logic [63:0] b, e, m, acc;
        b = {1'b0, it.base_value};
        e = {1'b0, it.exponent};
        m = {1'b0, it.modulus};
        r = '0;
        if (m == 0) begin
            r.zero_modulus_error = 1'b1;
            return r;
        end
        acc = 1;
        b = b % m;
        while (e != 0) begin
            if (e[0]) acc = mul_reduce(acc % m, b, m);
            e = e >> 1;
            b = mul_reduce(b, b, m);
        end
        r.power_result = acc[FIELD_W-1:0];
        return r;
    endfunction

    initial begin
        o_fail_count = 0;
        o_seen = 0;
    end

    assign o_pending = expected_results.size();

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && i_in_valid && !i_in_stall)
            expected_results.push_back(power_mod(i_in));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            o_seen <= o_seen + 1;
            if (expected_results.size() == 0) begin
                $error("unexpected result item %0d", i_out.power_result);
                o_fail_count <= o_fail_count + 1;
            end else begin
                want = expected_results.pop_front();
                if (want.power_result !== i_out.power_result) begin
                    $error("power_result: expected %0d, got %0d",
                           want.power_result, i_out.power_result);
                    o_fail_count <= o_fail_count + 1;
                end
                if (want.zero_modulus_error !== i_out.zero_modulus_error) begin
                    $error("zero_modulus_error: expected %0d, got %0d",
                           want.zero_modulus_error, i_out.zero_modulus_error);
                    o_fail_count <= o_fail_count + 1;
                end
            end
        end
    end
endmodule

FILE: dv/tb_modular_exponentiation.sv
// Testbench top for the modular exponentiation block: drives items, stalls
// the output, and reports the verdict. Depends on modexp_pkg and modexp_checker.
`timescale 1ns / 100ps

module tb_modular_exponentiation;
    import modexp_pkg::*;

    localparam int RANDOM_ITEMS = 120;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_item  in_item;
    logic      out_valid;
    logic      out_stall;
    t_out_item out_item;
    int        fail_count;
    int        pending;
    int        seen;
    int        sent;
    bit        sending_done;
    bit        hold_off_done;

    t_in_item  directed_items[$];

    modular_exponentiation uut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out(out_item)
    );

    modexp_checker checker_i (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out(out_item),
        .o_fail_count(fail_count), .o_pending(pending), .o_seen(seen)
    );

    always begin
        clk = 1'b0; #10;
        clk = 1'b1; #10;
    end

    // Random 63-bit value
    function automatic logic [62:0] rand63();
        return 63'({$urandom(), $urandom()});
    endfunction

    // Value of random bit length, 1 to max_bits; small limits keep the run quick
    function automatic logic [62:0] rand_sized(int max_bits);
        int n;
        n = $urandom_range(max_bits, 1);
        return rand63() & ((63'd1 << n) - 63'd1);
    endfunction

    function automatic t_in_item make_item(logic [62:0] b, logic [62:0] e,
                                           logic [62:0] m);
        t_in_item it;
        it.base_value = b;
        it.exponent = e;
        it.modulus = m;
        return it;
    endfunction

    // Offer one item after a random gap; hold it steady until taken
    task automatic send_item(t_in_item it);
        int gap;
        gap = $urandom_range(7, 0);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        @(negedge clk);
        sent++;
    endtask

    // Sender: directed corner items, then random ones
    initial begin
        logic [62:0] all_ones;
        t_in_item    it;
        all_ones = '1;
        in_valid = 1'b0;
        in_item = '0;
        rst_n = 1'b0;
        sent = 0;
        sending_done = 1'b0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // zero modulus, with and without zero exponent
        directed_items.push_back(make_item(63'd5, 63'd3, 63'd0));
        directed_items.push_back(make_item(all_ones, 63'd0, 63'd0));
        // zero exponent answers 1 unreduced, even with modulus one
        directed_items.push_back(make_item(63'd7, 63'd0, 63'd1));
        directed_items.push_back(make_item(all_ones, 63'd0, all_ones));
        // modulus one with nonzero exponent
        directed_items.push_back(make_item(63'd9, 63'd4, 63'd1));
        // zero base, base equal to and above modulus
        directed_items.push_back(make_item(63'd0, 63'd5, 63'd13));
        directed_items.push_back(make_item(63'd13, 63'd5, 63'd13));
        directed_items.push_back(make_item(63'd100, 63'd7, 63'd13));
        // full-width extremes
        directed_items.push_back(make_item(all_ones, all_ones, all_ones));
        directed_items.push_back(make_item(all_ones - 1, all_ones, all_ones));
        directed_items.push_back(make_item(all_ones, 63'd2, all_ones - 1));
        directed_items.push_back(make_item(63'd2, 63'd62, all_ones));
        directed_items.push_back(make_item(63'h5555_5555_5555_5555,
                                           63'h2AAA_AAAA_AAAA_AAAA, all_ones));
        directed_items.push_back(make_item(63'h2AAA_AAAA_AAAA_AAAA,
                                           63'h5555_5555_5555_5555,
                                           63'h5555_5555_5555_5555));
        // a modulus just above 2^32, then modulus two
        directed_items.push_back(make_item(63'hFFFF_FFFF, 63'd3, 63'h1_0000_0001));
        directed_items.push_back(make_item(63'd1, 63'd1, 63'd2));
        foreach (directed_items[k]) send_item(directed_items[k]);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            case ($urandom_range(9, 0))
                0: it = make_item(rand63(), rand_sized(6), 63'd0);
                1: it = make_item(rand63(), 63'd0, rand_sized(63));
                2: it = make_item(rand63(), rand63(), rand63());
                3: it = make_item(rand63(), rand_sized(8), rand63());
                default: it = make_item(rand_sized(63), rand_sized(12),
                                        rand_sized(63));
            endcase
            send_item(it);
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // Receiver: a random wait before each item, and one long hold-off early on
    // so the block fills up and stalls its input while items keep coming
    initial begin
        int gap;
        out_stall = 1'b1;
        hold_off_done = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (!hold_off_done && sent >= 3) begin
                out_stall <= 1'b1;
                repeat (300) @(negedge clk);
                hold_off_done = 1'b1;
                out_stall <= 1'b0;
            end else begin
                // stretch with no stalls at all
                gap = (sent > 60 && sent < 80) ? 0 : $urandom_range(7, 0);
                if (gap != 0) begin
                    out_stall <= 1'b1;
                    repeat (gap) @(negedge clk);
                end
                out_stall <= 1'b0;
                do @(posedge clk); while (!out_valid);
            end
        end
    end

    // Verdict once everything sent has come back
    initial begin
        wait (sending_done);
        wait (pending == 0);
        repeat (200) @(posedge clk);
        $display("Sent %0d items (%0d directed corners, rest random widths and", sent,
                 directed_items.size());
        $display("zero-modulus/zero-exponent mixes); %0d results checked", seen);
        if (fail_count == 0 && pending == 0)
            $display("modular_exponentiation regression: pass");
        else
            $display("modular_exponentiation regression: fail");
        $finish;
    end

    // Limit: a timeout that ends the run as a fail
    initial begin
        #200_000_000;
        $display("modular_exponentiation regression: fail");
        $finish;
    end
endmodule
